// File: sv/prime_factor_count_compare_defines.svh
// Assertion macros shared by the prime factor count compare RTL.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef PRIME_FACTOR_COUNT_COMPARE_DEFINES_SVH
`define PRIME_FACTOR_COUNT_COMPARE_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define PFCC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define PFCC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the following cycle.
`define PFCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pfcc_pkg.sv
// Shared types, constants and microprogram ROM of the prime factor count compare block.
// No dependencies; used by the interfaces and the top level.
package pfcc_pkg;

  localparam int IN_W      = 32;
  localparam int COUNT_W   = 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
  localparam int FIRST_DIVISOR = 2;

  // Microprogram counter and step addresses
  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_WAIT   = 4'd0;
  localparam upc_t UPC_INIT_A = 4'd1;
  localparam upc_t UPC_DSTART = 4'd2;
  localparam upc_t UPC_DWAIT  = 4'd3;
  localparam upc_t UPC_TEST   = 4'd4;
  localparam upc_t UPC_STEP   = 4'd5;
  localparam upc_t UPC_TAIL   = 4'd6;
  localparam upc_t UPC_INIT_B = 4'd7;
  localparam upc_t UPC_EMIT   = 4'd8;
  localparam upc_t UPC_RET    = 4'd9;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LATCH,
    OP_INIT_A,
    OP_INIT_B,
    OP_DIV_START,
    OP_STEP,
    OP_TAIL,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_DIV_BUSY,
    C_D_GT_Q,
    C_SEL_B,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ctrl_t;

  // Control ROM: jump to target when cond is true, else fall through.
  function automatic ctrl_t ucode(input upc_t pc);
    ctrl_t w;
    case (pc)
      UPC_WAIT:   w = '{op: OP_LATCH,     cond: C_NO_IN,    target: UPC_WAIT};
      UPC_INIT_A: w = '{op: OP_INIT_A,    cond: C_NEVER,    target: UPC_WAIT};
      UPC_DSTART: w = '{op: OP_DIV_START, cond: C_NEVER,    target: UPC_WAIT};
      UPC_DWAIT:  w = '{op: OP_NOP,       cond: C_DIV_BUSY, target: UPC_DWAIT};
      UPC_TEST:   w = '{op: OP_NOP,       cond: C_D_GT_Q,   target: UPC_TAIL};
      UPC_STEP:   w = '{op: OP_STEP,      cond: C_ALWAYS,   target: UPC_DSTART};
      UPC_TAIL:   w = '{op: OP_TAIL,      cond: C_SEL_B,    target: UPC_EMIT};
      UPC_INIT_B: w = '{op: OP_INIT_B,    cond: C_ALWAYS,   target: UPC_DSTART};
      UPC_EMIT:   w = '{op: OP_EMIT,      cond: C_OUT_BUSY, target: UPC_EMIT};
      UPC_RET:    w = '{op: OP_NOP,       cond: C_ALWAYS,   target: UPC_WAIT};
      default:    w = '{op: OP_NOP,       cond: C_ALWAYS,   target: UPC_WAIT};
    endcase
    return w;
  endfunction

endpackage

// File: sv/pfcc_ifs.sv
// Valid/ready channel interfaces for the input pair and the result beat.
// Depends on pfcc_pkg for the field widths.
interface pfcc_in_if import pfcc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] value_a;
  logic signed [IN_W-1:0] value_b;

  modport source (output valid, output value_a, output value_b, input ready);
  modport sink   (input valid, input value_a, input value_b, output ready);
endinterface

interface pfcc_out_if import pfcc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count_a;
  logic [COUNT_W-1:0] count_b;
  logic               a_first;

  modport source (output valid, output count_a, output count_b, output a_first,
                  input ready);
  modport sink   (input valid, input count_a, input count_b, input a_first,
                  output ready);
endinterface

// File: sv/pfcc_divider.sv
// Restoring radix-2 divider: one quotient bit per cycle, quotient and remainder.
// Depends on prime_factor_count_compare_defines.svh for assertion macros.
`include "prime_factor_count_compare_defines.svh"

module pfcc_divider #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CTW = $clog2(W + 1);

  logic           busy_r, busy_nxt;
  logic [CTW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]   quo_r, quo_nxt;
  logic [W-1:0]   rem_r, rem_nxt;
  logic [W-1:0]   div_r, div_nxt;

  logic [W:0] trial;
  logic [W:0] diff;
  logic       ge;

  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CTW'(W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      // shift one dividend bit into the partial remainder, restore on borrow
      rem_nxt  = ge ? diff[W-1:0] : trial[W-1:0];
      quo_nxt  = {quo_r[W-2:0], ge};
      cnt_nxt  = cnt_r - CTW'(1);
      busy_nxt = (cnt_r != CTW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign busy = busy_r;
  assign quot = quo_r;
  assign rem  = rem_r;

  `PFCC_ASSERT_IMPL(a_div_no_restart, start, !busy_r, "divider started while busy")
  `PFCC_ASSERT_IMPL(a_div_count_live, busy_r, cnt_r != '0, "divider busy with zero count")
  `PFCC_ASSERT_IMPL(a_div_rem_small, $fell(busy_r), rem_r < div_r,
                    "remainder not below divisor")

endmodule

// File: sv/prime_factor_count_compare.sv
// Top level: compares two integers by their prime factor count with multiplicity.
// Depends on pfcc_pkg, pfcc_ifs.sv, pfcc_divider and the assertion macro header.
//
//   channel | dir | payload                              | handshake
//   --------+-----+--------------------------------------+-------------------
//   in_bus  | in  | value_a[31:0], value_b[31:0] signed  | valid/ready beat
//   out_bus | out | count_a[4:0], count_b[4:0], a_first  | valid/ready beat
//
// Each trial divisor runs the bit-serial divider that yields quotient and
// remainder. One value takes one division per trial divisor and per factor
// found, with trial divisors up to sqrt(value), and an item does both values.
// Reset: synchronous active-low rst_n clears the sequencer and output valid.
// Stalls: a held result beat does not block accepting the next pair; the block
// only waits at the emit step if the previous result is still not taken.
`include "prime_factor_count_compare_defines.svh"

module prime_factor_count_compare import pfcc_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  pfcc_in_if.sink    in_bus,
  pfcc_out_if.source out_bus
);

  localparam int W     = VALUE_WIDTH;
  localparam int CW    = $clog2(VALUE_WIDTH);
  localparam int CMP_W = (CW > COUNT_W) ? CW : COUNT_W;

  // Sequencer
  upc_t  pc_r, pc_nxt;
  ctrl_t cw;
  logic  cond_true;

  // Datapath
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  m_r, m_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt;
  logic [CW-1:0] cnt_b_r, cnt_b_nxt;
  logic          sel_r, sel_nxt;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_a_r, out_count_a_nxt;
  logic [COUNT_W-1:0] out_count_b_r, out_count_b_nxt;
  logic               out_a_first_r, out_a_first_nxt;

  // Divider hookup
  logic         div_start;
  logic         div_busy;
  logic [W-1:0] div_quot;
  logic [W-1:0] div_rem;

  logic          in_fire;
  logic          out_fire;
  logic          out_free;
  logic [W-1:0]  in_a_ext;
  logic [W-1:0]  in_b_ext;
  logic [CW-1:0] cnt_fin;

  assign cw       = ucode(pc_r);
  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_fire = out_bus.valid && out_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;

  // Take the low VALUE_WIDTH bits, sign-extended when the width exceeds the port
  assign in_a_ext = W'(in_bus.value_a);
  assign in_b_ext = W'(in_bus.value_b);

  // A leftover cofactor above one is one more prime
  assign cnt_fin = cnt_r + CW'(m_r > W'(1));

  assign div_start = (cw.op == OP_DIV_START);

  pfcc_divider #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (m_r),
    .divisor  (d_r),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  function automatic logic [COUNT_W-1:0] sat_count(input logic [CW-1:0] c);
    return (CMP_W'(c) > CMP_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(c);
  endfunction

  // Jump condition of the current control word
  always_comb begin
    case (cw.cond)
      C_NEVER:    cond_true = 1'b0;
      C_ALWAYS:   cond_true = 1'b1;
      C_NO_IN:    cond_true = !in_fire;
      C_DIV_BUSY: cond_true = div_busy;
      C_D_GT_Q:   cond_true = d_r > div_quot;
      C_SEL_B:    cond_true = sel_r;
      C_OUT_BUSY: cond_true = !out_free;
      default:    cond_true = 1'b1;
    endcase
  end

  assign pc_nxt = cond_true ? cw.target : pc_r + upc_t'(1);

  // Datapath actions
  always_comb begin
    a_nxt           = a_r;
    b_nxt           = b_r;
    m_nxt           = m_r;
    d_nxt           = d_r;
    cnt_nxt         = cnt_r;
    cnt_a_nxt       = cnt_a_r;
    cnt_b_nxt       = cnt_b_r;
    sel_nxt         = sel_r;
    out_valid_nxt   = out_valid_r && !out_bus.ready;
    out_count_a_nxt = out_count_a_r;
    out_count_b_nxt = out_count_b_r;
    out_a_first_nxt = out_a_first_r;
    case (cw.op)
      OP_LATCH: begin
        if (in_fire) begin
          a_nxt = in_a_ext;
          b_nxt = in_b_ext;
        end
      end
      OP_INIT_A: begin
        // negative values start from zero so that they count zero
        m_nxt   = a_r[W-1] ? '0 : a_r;
        d_nxt   = W'(FIRST_DIVISOR);
        cnt_nxt = '0;
        sel_nxt = 1'b0;
      end
      OP_INIT_B: begin
        m_nxt   = b_r[W-1] ? '0 : b_r;
        d_nxt   = W'(FIRST_DIVISOR);
        cnt_nxt = '0;
        sel_nxt = 1'b1;
      end
      OP_STEP: begin
        // divisor found: take it out once; otherwise advance the divisor
        if (div_rem == '0) begin
          m_nxt   = div_quot;
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          d_nxt = d_r + W'(1);
        end
      end
      OP_TAIL: begin
        if (sel_r) cnt_b_nxt = cnt_fin;
        else       cnt_a_nxt = cnt_fin;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_count_a_nxt = sat_count(cnt_a_r);
          out_count_b_nxt = sat_count(cnt_b_r);
          // order by count, then by signed value
          if (cnt_a_r == cnt_b_r) out_a_first_nxt = $signed(a_r) > $signed(b_r);
          else                    out_a_first_nxt = cnt_a_r > cnt_b_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= UPC_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r           <= a_nxt;
    b_r           <= b_nxt;
    m_r           <= m_nxt;
    d_r           <= d_nxt;
    cnt_r         <= cnt_nxt;
    cnt_a_r       <= cnt_a_nxt;
    cnt_b_r       <= cnt_b_nxt;
    sel_r         <= sel_nxt;
    out_count_a_r <= out_count_a_nxt;
    out_count_b_r <= out_count_b_nxt;
    out_a_first_r <= out_a_first_nxt;
  end

  assign in_bus.ready    = (pc_r == UPC_WAIT);
  assign out_bus.valid   = out_valid_r;
  assign out_bus.count_a = out_count_a_r;
  assign out_bus.count_b = out_count_b_r;
  assign out_bus.a_first = out_a_first_r;

  `PFCC_ASSERT_IMPL(a_accept_div_idle, in_fire, !div_busy, "pair accepted while dividing")
  `PFCC_ASSERT_IMPL(a_divisor_min, pc_r == UPC_DWAIT, d_r >= W'(FIRST_DIVISOR),
                    "trial divisor below the first divisor")
  `PFCC_ASSERT_NEXT(a_beat_drops, out_fire && (pc_r != UPC_EMIT), !out_valid_r,
                    "result beat repeated after it was taken")

endmodule
